FILE: sv/hes_pkg.sv
// Shared constants, types and the output clip function of the Hencky energy and stress core.
package hes_pkg;

    localparam int DIMENSION      = 3;
    localparam bit USE_THIRD      = (DIMENSION > 2);
    localparam int S_W            = 24;
    localparam int L_W            = 30;
    localparam int NUM_W          = 64;
    localparam int OUT_W          = 48;
    localparam int FRAC_BITS      = 24;
    localparam int LOG_LAT        = FRAC_BITS + 3;
    localparam int MIX_LAT        = 5;
    localparam int DIV_STEPS      = 12;
    localparam int DIV_RADIX_BITS = 4;
    localparam int QUO_W          = DIV_STEPS * DIV_RADIX_BITS;
    localparam int DIV_LAT        = DIV_STEPS + 2;
    localparam int TOTAL_LAT      = LOG_LAT + MIX_LAT + DIV_LAT + 1;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef logic [S_W-1:0]          stretch_t;
    typedef logic signed [L_W-1:0]   ln_t;
    typedef logic signed [NUM_W-1:0] num_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } res_t;

    function automatic res_t clip_out(input logic signed [NUM_W-1:0] v);
        res_t                    r;
        logic signed [NUM_W-1:0] hi;
        logic signed [NUM_W-1:0] lo;
        hi = NUM_W'(OUT_MAX);
        lo = NUM_W'(OUT_MIN);
        if (v > hi)
        begin
            r.value = OUT_MAX;
            r.sat   = 1'b1;
        end
        else if (v < lo)
        begin
            r.value = OUT_MIN;
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = v[OUT_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/hes_log_lane.sv
// Pipelined natural log of one Q8.16 stretch: normalize, 24 squaring stages, scale by ln 2.
module hes_log_lane (
    input  logic             clk,
    input  logic             en,
    input  hes_pkg::stretch_t s,
    output hes_pkg::ln_t      l
);
    import hes_pkg::*;

    logic [4:0]                 msb;
    logic [31:0]                m_reg     [0:FRAC_BITS];
    logic [31:0]                m_next    [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]       frac_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]       frac_next [0:FRAC_BITS];
    logic signed [5:0]          exp_reg   [0:FRAC_BITS];
    logic signed [5:0]          exp_next  [0:FRAC_BITS];
    logic [63:0]                sq        [0:FRAC_BITS-1];
    logic signed [5+FRAC_BITS:0] l2;
    logic signed [62:0]         prod_next;
    logic signed [62:0]         prod_reg;
    logic signed [62:0]         rnd;
    ln_t                        l_reg;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < S_W; i++)
        begin
            if (s[i])
            begin
                msb = 5'(i);
            end
        end
        // mantissa as Q1.31 with the top set bit at bit 31
        m_next[0]    = {8'd0, s} << (5'd31 - msb);
        frac_next[0] = '0;
        exp_next[0]  = $signed({1'b0, msb}) - 6'sd16;
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            sq[k] = 64'(m_reg[k]) * 64'(m_reg[k]);
            if (sq[k][63])
            begin
                m_next[k+1]    = sq[k][63:32];
                frac_next[k+1] = {frac_reg[k][FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                m_next[k+1]    = sq[k][62:31];
                frac_next[k+1] = {frac_reg[k][FRAC_BITS-2:0], 1'b0};
            end
            exp_next[k+1] = exp_reg[k];
        end
        l2        = {exp_reg[FRAC_BITS], frac_reg[FRAC_BITS]};
        prod_next = l2 * $signed({1'b0, LN2_Q32});
        rnd       = prod_reg + (63'sd1 <<< 31);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= FRAC_BITS; k++)
            begin
                m_reg[k]    <= m_next[k];
                frac_reg[k] <= frac_next[k];
                exp_reg[k]  <= exp_next[k];
            end
            prod_reg <= prod_next;
            l_reg    <= rnd[61:32];
        end
    end

    assign l = l_reg;

endmodule

FILE: sv/hes_mix.sv
// Five-stage combine of the logs: trace, squared sums, energy and stress numerators.
module hes_mix (
    input  logic               clk,
    input  logic               en,
    input  hes_pkg::ln_t       l [0:2],
    input  logic [31:0]        mu,
    input  logic signed [31:0] lam,
    output hes_pkg::res_t      energy,
    output hes_pkg::num_t      num [0:2]
);
    import hes_pkg::*;

    ln_t                lu [0:2];
    logic signed [31:0] tr_next, tr_a;
    logic signed [59:0] psq_next [0:2];
    logic signed [59:0] psq_a    [0:2];
    logic signed [62:0] ml_next  [0:2];
    logic signed [62:0] ml_a     [0:2];
    logic signed [62:0] ml_b     [0:2];
    logic [31:0]        mu_a, mu_b, mu_c;
    logic signed [31:0] lam_a, lam_b, lam_c;
    logic signed [61:0] sq_next, sq_b, sq_rnd;
    logic signed [63:0] tt_next, tt_b, tt_rnd;
    logic signed [63:0] lt_next, lt_b;
    logic [31:0]        esq_c, trsq_c;
    num_t               num_next [0:2];
    num_t               num_c    [0:2];
    num_t               num_d    [0:2];
    num_t               num_e    [0:2];
    logic signed [63:0] e1_next, e1_d, e2_next, e2_d, e_sum, e_rnd;
    res_t               energy_next, energy_e;

    always_comb
    begin
        lu[0] = l[0];
        lu[1] = l[1];
        lu[2] = USE_THIRD ? l[2] : '0;
        tr_next = 32'(lu[0]) + 32'(lu[1]) + 32'(lu[2]);
        for (int i = 0; i < 3; i++)
        begin
            psq_next[i] = lu[i] * lu[i];
            ml_next[i]  = $signed({1'b0, mu}) * lu[i];
        end
        sq_next = 62'(psq_a[0]) + 62'(psq_a[1]) + 62'(psq_a[2]);
        tt_next = tr_a * tr_a;
        lt_next = lam_a * tr_a;
        // round half up to Q.20
        sq_rnd = sq_b + (62'sd1 <<< 27);
        tt_rnd = tt_b + (64'sd1 <<< 27);
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = (64'(ml_b[i]) <<< 1) + lt_b;
        end
        e1_next     = $signed({1'b0, mu_c, 1'b0}) * $signed({1'b0, esq_c});
        e2_next     = lam_c * $signed({1'b0, trsq_c});
        e_sum       = e1_d + e2_d;
        e_rnd       = e_sum + (64'sd1 <<< 20);
        energy_next = clip_out(e_rnd >>> 21);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_a   <= tr_next;
            psq_a  <= psq_next;
            ml_a   <= ml_next;
            mu_a   <= mu;
            lam_a  <= lam;
            sq_b   <= sq_next;
            tt_b   <= tt_next;
            lt_b   <= lt_next;
            ml_b   <= ml_a;
            mu_b   <= mu_a;
            lam_b  <= lam_a;
            esq_c  <= sq_rnd[59:28];
            trsq_c <= tt_rnd[59:28];
            num_c  <= num_next;
            mu_c   <= mu_b;
            lam_c  <= lam_b;
            e1_d   <= e1_next;
            e2_d   <= e2_next;
            num_d  <= num_c;
            energy_e <= energy_next;
            num_e    <= num_d;
        end
    end

    assign energy = energy_e;
    assign num    = num_e;

endmodule

FILE: sv/hes_div_lane.sv
// Pipelined radix-16 restoring divide of a stress numerator by its stretch, rounded and clipped.
module hes_div_lane (
    input  logic              clk,
    input  logic              en,
    input  hes_pkg::num_t     num,
    input  hes_pkg::stretch_t s,
    output hes_pkg::res_t     res
);
    import hes_pkg::*;

    logic [63:0]       mag;
    logic [62:0]       nn;
    logic [6:0]        top;
    logic [S_W-1:0]    rem_reg  [0:DIV_STEPS];
    logic [S_W-1:0]    rem_next [0:DIV_STEPS];
    logic [QUO_W-1:0]  dv_reg   [0:DIV_STEPS];
    logic [QUO_W-1:0]  dv_next  [0:DIV_STEPS];
    logic [QUO_W-1:0]  q_reg    [0:DIV_STEPS];
    logic [QUO_W-1:0]  q_next   [0:DIV_STEPS];
    stretch_t          s_reg    [0:DIV_STEPS];
    logic              neg_reg  [0:DIV_STEPS];
    logic              ovf_reg  [0:DIV_STEPS];
    logic [S_W-1:0]    r;
    logic [S_W:0]      t;
    logic [QUO_W-1:0]  d;
    logic [QUO_W-1:0]  q;
    logic signed [63:0] v;
    res_t              res_next, res_reg;

    always_comb
    begin
        mag = num[63] ? 64'(-num) : 64'(num);
        // add half the divisor, then drop the 2^8 of the divisor from the dividend
        nn  = mag[62:0] + 63'({s, 7'd0});
        top = nn[62:56];
        rem_next[0] = {17'd0, top};
        dv_next[0]  = nn[55:8];
        q_next[0]   = '0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r = rem_reg[k];
            d = dv_reg[k];
            q = q_reg[k];
            for (int j = 0; j < DIV_RADIX_BITS; j++)
            begin
                t = {r, d[QUO_W-1]};
                d = d << 1;
                if (t >= {1'b0, s_reg[k]})
                begin
                    r = S_W'(t - {1'b0, s_reg[k]});
                    q = {q[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    r = t[S_W-1:0];
                    q = {q[QUO_W-2:0], 1'b0};
                end
            end
            rem_next[k+1] = r;
            dv_next[k+1]  = d;
            q_next[k+1]   = q;
        end
        v = neg_reg[DIV_STEPS] ? -$signed(64'(q_reg[DIV_STEPS]))
                               :  $signed(64'(q_reg[DIV_STEPS]));
        if (ovf_reg[DIV_STEPS])
        begin
            res_next.value = neg_reg[DIV_STEPS] ? OUT_MIN : OUT_MAX;
            res_next.sat   = 1'b1;
        end
        else
        begin
            res_next = clip_out(v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dv_reg[k]  <= dv_next[k];
                q_reg[k]   <= q_next[k];
            end
            s_reg[0]   <= s;
            neg_reg[0] <= num[63];
            // quotient would need more than QUO_W bits
            ovf_reg[0] <= ({17'd0, top} >= s);
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                s_reg[k]   <= s_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: sv/hencky_energy_and_stress_core.sv
// Top level of the Hencky energy and stress core: log lanes, combine stage, divide lanes.
//
// Takes one element per clock (principal stretches Q8.16, shear modulus Q16.16, signed Lame
// lambda Q16.16) and returns its strain energy and diagonal first Piola stresses as signed
// Q32.16, clipped with a saturated flag, plus an invalid flag when a used stretch is zero
// (all results then zero). The pipeline is 47 registers deep, and a new item can
// enter every cycle in which no finished result is held on result_stall, so the
// sustained rate is one element per clock. Most of the depth is the log2 of each stretch, one
// 32x32 squaring per stage for 24 fraction bits; a five-stage combine forms the trace, squared
// sums, energy and stress numerators, and a 14-stage radix-16 divider per lane forms the
// rounded stress. The whole pipeline holds while a result waits on result_stall; item_stall
// follows from that, and no item is dropped or repeated. The unused third lane is masked when
// DIMENSION is 2.
module hencky_energy_and_stress_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [23:0]         stretch_0,
    input  logic [23:0]         stretch_1,
    input  logic [23:0]         stretch_2,
    input  logic [31:0]         shear_modulus,
    input  logic signed [31:0]  lame_lambda,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [47:0]  energy,
    output logic signed [47:0]  stress_0,
    output logic signed [47:0]  stress_1,
    output logic signed [47:0]  stress_2,
    output logic                invalid,
    output logic                saturated
);
    import hes_pkg::*;

    typedef struct packed {
        stretch_t [2:0]     s;
        logic [31:0]        mu;
        logic signed [31:0] lam;
        logic               invalid;
    } front_t;

    typedef struct packed {
        stretch_t [2:0] s;
        logic           invalid;
    } back_t;

    typedef struct packed {
        res_t energy;
        logic invalid;
    } tail_t;

    logic   en;
    logic   valid_reg [0:TOTAL_LAT-1];
    front_t front_in;
    front_t front_reg [0:LOG_LAT-1];
    back_t  back_reg  [0:MIX_LAT-1];
    tail_t  tail_reg  [0:DIV_LAT-1];
    ln_t    ln        [0:2];
    res_t   energy_mix;
    num_t   num_mix   [0:2];
    res_t   res_div   [0:2];
    tail_t  tl;

    logic signed [OUT_W-1:0] energy_next, energy_reg;
    logic signed [OUT_W-1:0] stress0_next, stress0_reg;
    logic signed [OUT_W-1:0] stress1_next, stress1_reg;
    logic signed [OUT_W-1:0] stress2_next, stress2_reg;
    logic                    invalid_next, invalid_reg;
    logic                    sat_next, sat_reg;

    // advance everything unless the finished result is held by the receiver
    assign en         = !(valid_reg[TOTAL_LAT-1] && result_stall);
    assign item_stall = !en;

    always_comb
    begin
        front_in.s[0]   = stretch_0;
        front_in.s[1]   = stretch_1;
        front_in.s[2]   = stretch_2;
        front_in.mu     = shear_modulus;
        front_in.lam    = lame_lambda;
        front_in.invalid = (stretch_0 == '0) || (stretch_1 == '0)
                           || (USE_THIRD && (stretch_2 == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOTAL_LAT; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= item_valid;
            for (int k = 1; k < TOTAL_LAT; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // side data rides along with the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg[0] <= front_in;
            for (int k = 1; k < LOG_LAT; k++)
            begin
                front_reg[k] <= front_reg[k-1];
            end
            back_reg[0].s       <= front_reg[LOG_LAT-1].s;
            back_reg[0].invalid <= front_reg[LOG_LAT-1].invalid;
            for (int k = 1; k < MIX_LAT; k++)
            begin
                back_reg[k] <= back_reg[k-1];
            end
            tail_reg[0].energy  <= energy_mix;
            tail_reg[0].invalid <= back_reg[MIX_LAT-1].invalid;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                tail_reg[k] <= tail_reg[k-1];
            end
            energy_reg  <= energy_next;
            stress0_reg <= stress0_next;
            stress1_reg <= stress1_next;
            stress2_reg <= stress2_next;
            invalid_reg <= invalid_next;
            sat_reg     <= sat_next;
        end
    end

    hes_log_lane u_log_0 (.clk(clk), .en(en), .s(stretch_0), .l(ln[0]));
    hes_log_lane u_log_1 (.clk(clk), .en(en), .s(stretch_1), .l(ln[1]));
    hes_log_lane u_log_2 (.clk(clk), .en(en), .s(stretch_2), .l(ln[2]));

    hes_mix u_mix (
        .clk    (clk),
        .en     (en),
        .l      (ln),
        .mu     (front_reg[LOG_LAT-1].mu),
        .lam    (front_reg[LOG_LAT-1].lam),
        .energy (energy_mix),
        .num    (num_mix)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        hes_div_lane u_div (
            .clk (clk),
            .en  (en),
            .num (num_mix[i]),
            .s   (back_reg[MIX_LAT-1].s[i]),
            .res (res_div[i])
        );
    end

    // zero everything for a zero stretch; drop the third lane in two dimensions
    always_comb
    begin
        tl           = tail_reg[DIV_LAT-1];
        invalid_next = tl.invalid;
        if (tl.invalid)
        begin
            energy_next  = '0;
            stress0_next = '0;
            stress1_next = '0;
            stress2_next = '0;
            sat_next     = 1'b0;
        end
        else
        begin
            energy_next  = tl.energy.value;
            stress0_next = res_div[0].value;
            stress1_next = res_div[1].value;
            stress2_next = USE_THIRD ? res_div[2].value : '0;
            sat_next     = tl.energy.sat || res_div[0].sat || res_div[1].sat
                           || (USE_THIRD && res_div[2].sat);
        end
    end

    assign result_valid = valid_reg[TOTAL_LAT-1];
    assign energy       = energy_reg;
    assign stress_0     = stress0_reg;
    assign stress_1     = stress1_reg;
    assign stress_2     = stress2_reg;
    assign invalid      = invalid_reg;
    assign saturated    = sat_reg;

endmodule

FILE: sv/hes_check.sv
// Port-level checker for the Hencky energy and stress core, bound to the top level.
module hes_check (
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [47:0] energy,
    input logic signed [47:0] stress_0,
    input logic signed [47:0] stress_1,
    input logic signed [47:0] stress_2,
    input logic               invalid,
    input logic               saturated
);
    import hes_pkg::*;

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("input taken while the result is held");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(energy)
            && $stable(stress_0) && $stable(stress_1) && $stable(stress_2))
        else $error("held result changed");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && invalid |-> energy == '0 && stress_0 == '0
            && stress_1 == '0 && stress_2 == '0 && !saturated)
        else $error("invalid result not cleared");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |-> energy == OUT_MAX || energy == OUT_MIN
            || stress_0 == OUT_MAX || stress_0 == OUT_MIN
            || stress_1 == OUT_MAX || stress_1 == OUT_MIN
            || stress_2 == OUT_MAX || stress_2 == OUT_MIN)
        else $error("saturated flag without a clipped result");

    a_third_unused: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> USE_THIRD || stress_2 == '0)
        else $error("third stress nonzero in two dimensions");

endmodule

bind hencky_energy_and_stress_core hes_check u_hes_check (.*);
